FILE: hdl/sttf_pkg.sv
// ----------------------------------------------------------------------------
// sttf_pkg
// shared sizes, weights, result type and popcount helper for the
// sum-of-products fitness scorer
// ----------------------------------------------------------------------------
package sttf_pkg;

	localparam int TERMS      = 16;
	localparam int VARIABLES  = 4;
	localparam int NBITS      = TERMS * VARIABLES;
	localparam int NSTATES    = 1 << VARIABLES;

	localparam int MASK_W     = 64;
	localparam int TABLE_W    = 16;
	localparam int FIT_W      = 18;
	localparam int CNT_W      = 5;
	localparam int LIT_W      = 7;

	// popcount works on 16-bit groups built from four nibbles
	localparam int GROUP_W    = 16;
	localparam int NIBBLES    = GROUP_W / 4;
	localparam int LIT_GROUPS = (NBITS + GROUP_W - 1) / GROUP_W;
	localparam int PAD_W      = LIT_GROUPS * GROUP_W;

	localparam int CORRECT_WEIGHT = 10000;
	localparam int TERM_WEIGHT    = 100;
	localparam logic [TABLE_W-1:0] TABLE_RESET = 16'd15125;

	typedef struct packed {
		logic [FIT_W-1:0] fitness;
		logic [CNT_W-1:0] correct_count;
		logic [CNT_W-1:0] term_count;
		logic [LIT_W-1:0] literal_count;
	} sttf_result_t;

	// two-level count: nibble sums, then sum of nibbles
	function automatic logic [CNT_W-1:0] popcount16(input logic [GROUP_W-1:0] v);
		logic [2:0]       nib [NIBBLES];
		logic [CNT_W-1:0] sum;
		for (int g = 0; g < NIBBLES; g++) begin
			nib[g] = '0;
			for (int b = 0; b < 4; b++) begin
				nib[g] = nib[g] + 3'(v[g*4+b]);
			end
		end
		sum = '0;
		for (int g = 0; g < NIBBLES; g++) begin
			sum = sum + CNT_W'(nib[g]);
		end
		return sum;
	endfunction

endpackage

FILE: hdl/sttf_if.sv
// ----------------------------------------------------------------------------
// sttf_if
// valid/ready channels for genome input and score output
// ----------------------------------------------------------------------------
interface sttf_genome_if import sttf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MASK_W-1:0] used_mask;
	logic [MASK_W-1:0] invert_mask;

	modport source (output valid, output used_mask, output invert_mask, input ready);
	modport sink   (input valid, input used_mask, input invert_mask, output ready);
endinterface

interface sttf_score_if import sttf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [FIT_W-1:0] fitness;
	logic [CNT_W-1:0] correct_count;
	logic [CNT_W-1:0] term_count;
	logic [LIT_W-1:0] literal_count;

	modport source (output valid, output fitness, output correct_count,
		output term_count, output literal_count, input ready);
	modport sink   (input valid, input fitness, input correct_count,
		input term_count, input literal_count, output ready);
endinterface

FILE: hdl/sttf_lane.sv
// ----------------------------------------------------------------------------
// sttf_lane
// evaluates the expression for one input state and compares with the table
// ----------------------------------------------------------------------------
module sttf_lane import sttf_pkg::*; (
	input  logic [NBITS-1:0]     used,
	input  logic [NBITS-1:0]     invert,
	input  logic [VARIABLES-1:0] state,
	input  logic                 want,
	output logic                 match
);

	logic hit;
	logic term_any;
	logic term_all;

	always_comb begin
		hit = 1'b0;
		for (int t = 0; t < TERMS; t++) begin
			term_any = 1'b0;
			term_all = 1'b1;
			for (int v = 0; v < VARIABLES; v++) begin
				if (used[t*VARIABLES+v]) begin
					term_any = 1'b1;
					// literal false when variable equals its invert bit
					if (state[VARIABLES-1-v] == invert[t*VARIABLES+v]) begin
						term_all = 1'b0;
					end
				end
			end
			hit = hit | (term_any & term_all);
		end
		match = (hit == want);
	end

endmodule

FILE: hdl/sttf_merge.sv
// ----------------------------------------------------------------------------
// sttf_merge
// combines lane matches and mask counts into the final score, three stages
// ----------------------------------------------------------------------------
module sttf_merge import sttf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [NSTATES-1:0] match,
	input  logic [NBITS-1:0]   used,
	output logic               out_valid,
	input  logic               out_ready,
	output sttf_result_t       result
);

	logic ready_s2, ready_s3, ready_s4;
	logic valid_s2, valid_s3, valid_s4;

	logic [PAD_W-1:0] used_pad;
	logic [TERMS-1:0] term_used_c;
	logic [CNT_W-1:0] lit_grp_c [LIT_GROUPS];

	logic [CNT_W-1:0] lit_grp_s2 [LIT_GROUPS];
	logic [TERMS-1:0] term_used_s2;
	logic [CNT_W-1:0] correct_s2;

	logic [LIT_W-1:0] lit_sum_c;
	logic [LIT_W-1:0] lit_s3;
	logic [CNT_W-1:0] term_s3;
	logic [CNT_W-1:0] correct_s3;

	sttf_result_t     result_s4;

	assign ready_s4 = !valid_s4 || out_ready;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign in_ready = ready_s2;

	// stage 2 inputs: per-term usage and group literal counts
	assign used_pad = PAD_W'(used);

	always_comb begin
		for (int t = 0; t < TERMS; t++) begin
			term_used_c[t] = |used[t*VARIABLES +: VARIABLES];
		end
		for (int g = 0; g < LIT_GROUPS; g++) begin
			lit_grp_c[g] = popcount16(used_pad[g*GROUP_W +: GROUP_W]);
		end
	end

	always_comb begin
		lit_sum_c = '0;
		for (int g = 0; g < LIT_GROUPS; g++) begin
			lit_sum_c = lit_sum_c + LIT_W'(lit_grp_s2[g]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s2) valid_s2 <= in_valid;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && in_valid) begin
			lit_grp_s2   <= lit_grp_c;
			term_used_s2 <= term_used_c;
			correct_s2   <= popcount16(GROUP_W'(match));
		end
		if (ready_s3 && valid_s2) begin
			lit_s3     <= lit_sum_c;
			term_s3    <= popcount16(GROUP_W'(term_used_s2));
			correct_s3 <= correct_s2;
		end
		if (ready_s4 && valid_s3) begin
			result_s4.fitness <= FIT_W'(CORRECT_WEIGHT) * FIT_W'(correct_s3)
				+ FIT_W'(TERM_WEIGHT) * (FIT_W'(TERMS) - FIT_W'(term_s3))
				+ (FIT_W'(NBITS) - FIT_W'(lit_s3));
			result_s4.correct_count <= correct_s3;
			result_s4.term_count    <= term_s3;
			result_s4.literal_count <= lit_s3;
		end
	end

	assign out_valid = valid_s4;
	assign result    = result_s4;

endmodule

FILE: hdl/sop_truth_table_fitness.sv
// ----------------------------------------------------------------------------
// sop_truth_table_fitness
// scores a sum-of-products genome against a target truth table
// ----------------------------------------------------------------------------
// throughput: one genome per cycle unless score.ready stalls it, set by the
// four-stage valid/ready pipeline (lane stage, two count stages, fitness stage)
// each with its own hand-off, a score passing stage registers s1 through s4
// reset: arst_n clears all stage valids; truth table returns to 15125
// ----------------------------------------------------------------------------
module sop_truth_table_fitness import sttf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [TABLE_W-1:0] cfg_wdata,
	sttf_genome_if.sink        genome,
	sttf_score_if.source       score
);

	// target table, written by the user only with pipeline empty; not enforced
	logic [TABLE_W-1:0] truth_table_q;

	// only the low term*variable bits of each mask take part
	logic [NBITS-1:0]   used_lo;
	logic [NBITS-1:0]   inv_lo;

	// one lane per input state, each flags agreement with the table
	logic [NSTATES-1:0] match_c;

	// stage 1 registers sit between the lanes and the merge unit
	logic               valid_s1;
	logic               ready_s1;
	logic [NSTATES-1:0] match_s1;
	logic [NBITS-1:0]   used_s1;
	logic               merge_ready;

	sttf_result_t       result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			truth_table_q <= TABLE_RESET;
		end else if (cfg_we) begin
			truth_table_q <= cfg_wdata;
		end
	end

	assign used_lo = genome.used_mask[NBITS-1:0];
	assign inv_lo  = genome.invert_mask[NBITS-1:0];

	for (genvar s = 0; s < NSTATES; s++) begin : g_lane
		sttf_lane u_lane (
			.used   (used_lo),
			.invert (inv_lo),
			.state  (VARIABLES'(s)),
			.want   (truth_table_q[s]),
			.match  (match_c[s])
		);
	end

	// stage 1 takes a new genome whenever it is empty or moving on
	assign ready_s1     = !valid_s1 || merge_ready;
	assign genome.ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= genome.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && genome.valid) begin
			match_s1 <= match_c;
			used_s1  <= used_lo;
		end
	end

	// counts and weighted score
	sttf_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_ready  (merge_ready),
		.match     (match_s1),
		.used      (used_s1),
		.out_valid (score.valid),
		.out_ready (score.ready),
		.result    (result)
	);

	assign score.fitness       = result.fitness;
	assign score.correct_count = result.correct_count;
	assign score.term_count    = result.term_count;
	assign score.literal_count = result.literal_count;

endmodule

FILE: hdl/sttf_checker.sv
// ----------------------------------------------------------------------------
// sttf_checker
// port-level checks on score consistency, stalls and pipeline latency
// ----------------------------------------------------------------------------
module sttf_checker import sttf_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [FIT_W-1:0] fitness,
	input logic [CNT_W-1:0] correct_count,
	input logic [CNT_W-1:0] term_count,
	input logic [LIT_W-1:0] literal_count
);

	// fitness agrees with the three counts it is built from
	a_fitness_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> fitness == FIT_W'(CORRECT_WEIGHT) * FIT_W'(correct_count)
			+ FIT_W'(TERM_WEIGHT) * (FIT_W'(TERMS) - FIT_W'(term_count))
			+ (FIT_W'(NBITS) - FIT_W'(literal_count)))
		else $error("fitness does not match its counts");

	// correct count is at most the state count; every used term holds one to four literals
	a_count_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (correct_count <= CNT_W'(NSTATES))
			&& (LIT_W'(term_count) <= literal_count)
			&& (literal_count <= LIT_W'(VARIABLES) * LIT_W'(term_count)))
		else $error("term and literal counts inconsistent");

	// a stalled score stays valid with fitness and literal count stable
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(fitness)
			&& $stable(literal_count))
		else $error("stalled score changed");

	// with the sink ready, an accepted genome comes out as a valid score
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready ##1 out_ready [*3]) |=> out_valid)
		else $error("score missing after pipeline latency");

endmodule

bind sop_truth_table_fitness sttf_checker u_sttf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (genome.valid),
	.in_ready      (genome.ready),
	.out_valid     (score.valid),
	.out_ready     (score.ready),
	.fitness       (score.fitness),
	.correct_count (score.correct_count),
	.term_count    (score.term_count),
	.literal_count (score.literal_count)
);
